// ----- rtl/dba_pkg.sv -----
// ----------------------------------------------------------------------------
// Double booking admission: shared package
// Table sizes, time width, status codes, sequencer states and the interval
// record that is stored in both tables.
// ----------------------------------------------------------------------------
package dba_pkg;

   localparam int BOOKING_DEPTH = 64;
   localparam int OVERLAP_DEPTH = 64;
   localparam int TIME_BITS     = 32;

   // Width of the time fields on the ports.
   localparam int FIELD_BITS = 32;

   // Only the low TIME_W bits of each time field take part in the check; with these settings that is all of them.
   localparam int TIME_W = (TIME_BITS < FIELD_BITS) ? TIME_BITS : FIELD_BITS;

   localparam int BIDX_W = (BOOKING_DEPTH > 1) ? $clog2(BOOKING_DEPTH) : 1;
   localparam int OIDX_W = (OVERLAP_DEPTH > 1) ? $clog2(OVERLAP_DEPTH) : 1;
   localparam int BCNT_W = $clog2(BOOKING_DEPTH + 1);
   localparam int OCNT_W = $clog2(OVERLAP_DEPTH + 1);
   localparam int SCAN_W = (BCNT_W > OCNT_W) ? BCNT_W : OCNT_W;
   localparam int SUM_W  = SCAN_W + 1;

   typedef logic [TIME_W-1:0] time_type;

   typedef struct packed {
      time_type lo;
      time_type hi;
   } span_type;

   localparam int SPAN_W = $bits(span_type);

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_TRIPLE = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_SCAN_OVL = 7'b0000010,
      ST_COUNT    = 7'b0000100,
      ST_CHECK    = 7'b0001000,
      ST_WRITE    = 7'b0010000,
      ST_STORE    = 7'b0100000,
      ST_RESP     = 7'b1000000
   } state_type;

endpackage

// ----- rtl/dba_ram.sv -----
// ----------------------------------------------------------------------------
// Double booking admission: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/dba_ovl.sv -----
// ----------------------------------------------------------------------------
// Double booking admission: overlap unit
// The one comparator shared by every scan: finds the common part of a stored
// interval and the request, and whether it is non-empty.
// ----------------------------------------------------------------------------
module dba_ovl (
   input  dba_pkg::span_type entry,
   input  dba_pkg::span_type request,
   output logic              hit,
   output dba_pkg::span_type common
);

   always_comb begin
      common.lo = (entry.lo > request.lo) ? entry.lo : request.lo;
      common.hi = (entry.hi < request.hi) ? entry.hi : request.hi;
      hit       = common.lo < common.hi;
   end

endmodule

// ----- rtl/double_booking_admission.sv -----
// ----------------------------------------------------------------------------
// Double booking admission
// Admits half-open time intervals, refusing any that would create a triple
// booking or overflow the booking or double booked region tables.
// ----------------------------------------------------------------------------
// Usage:
// A request carries req_start_time and req_end_time and transfers when
// req_valid is high and req_stall is low. Each request yields exactly one
// rsp_status (accepted, triple booking, or table full), which transfers when
// rsp_valid is high and rsp_stall is low.
// One request is processed at a time. The single overlap unit and the single
// read port of each table set how long a request occupies the block; the
// next request is taken on the cycle after the result is loaded.
// Reset clears both entry counts and the result valid flag; table contents are
// never read beyond the counts, so no clearing pass is needed.
// While the receiver stalls, the result holds in the output register and the
// next request is still taken; its own result then waits in the last step
// until the output register frees up.
// ----------------------------------------------------------------------------
module double_booking_admission (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [dba_pkg::FIELD_BITS-1:0] req_start_time,
   input  logic [dba_pkg::FIELD_BITS-1:0] req_end_time,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_status
);

   dba_pkg::state_type  state_ff, state_in;
   dba_pkg::span_type   req_ff, req_in;
   logic [dba_pkg::SCAN_W-1:0] rd_ff, rd_in;
   logic                pend_ff, pend_in;
   logic [dba_pkg::BCNT_W-1:0] bcnt_ff, bcnt_in;
   logic [dba_pkg::OCNT_W-1:0] ocnt_ff, ocnt_in;
   logic [dba_pkg::BCNT_W-1:0] added_ff, added_in;
   dba_pkg::status_type status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dba_pkg::status_type rsp_status_ff, rsp_status_in;

   logic                       scanning;
   logic                       issue;
   logic                       scan_done;
   logic [dba_pkg::SCAN_W-1:0] scan_limit;
   logic [dba_pkg::SUM_W-1:0]  ovl_total;
   logic                       rsp_free;
   logic                       req_xfer;

   logic                         bk_wr_en, bk_rd_en;
   logic                         ov_wr_en, ov_rd_en;
   logic [dba_pkg::SPAN_W-1:0]   bk_rd_data, ov_rd_data;
   dba_pkg::span_type            entry;
   dba_pkg::span_type            common;
   logic                         hit;

   assign req_stall = (state_ff != dba_pkg::ST_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Read addresses stream one per cycle; pend_ff marks that the read data
   // of the previous address is on the RAM output this cycle.
   assign scanning   = (state_ff == dba_pkg::ST_SCAN_OVL) ||
                       (state_ff == dba_pkg::ST_COUNT) ||
                       (state_ff == dba_pkg::ST_WRITE);
   assign scan_limit = (state_ff == dba_pkg::ST_SCAN_OVL) ?
                       dba_pkg::SCAN_W'(ocnt_ff) : dba_pkg::SCAN_W'(bcnt_ff);
   assign issue      = scanning && (rd_ff < scan_limit);
   assign scan_done  = !issue && !pend_ff;
   assign ovl_total  = dba_pkg::SUM_W'(ocnt_ff) + dba_pkg::SUM_W'(added_ff);

   assign entry = (state_ff == dba_pkg::ST_SCAN_OVL) ?
                  dba_pkg::span_type'(ov_rd_data) : dba_pkg::span_type'(bk_rd_data);

   assign bk_rd_en = issue && (state_ff != dba_pkg::ST_SCAN_OVL);
   assign bk_wr_en = (state_ff == dba_pkg::ST_STORE);
   assign ov_rd_en = issue && (state_ff == dba_pkg::ST_SCAN_OVL);
   assign ov_wr_en = (state_ff == dba_pkg::ST_WRITE) && pend_ff && hit;

   dba_ovl u_ovl (
      .entry   (entry),
      .request (req_ff),
      .hit     (hit),
      .common  (common)
   );

   dba_ram #(
      .WIDTH (dba_pkg::SPAN_W),
      .DEPTH (dba_pkg::BOOKING_DEPTH)
   ) u_booking_ram (
      .clock   (clock),
      .wr_en   (bk_wr_en),
      .wr_addr (bcnt_ff[dba_pkg::BIDX_W-1:0]),
      .wr_data (req_ff),
      .rd_en   (bk_rd_en),
      .rd_addr (rd_ff[dba_pkg::BIDX_W-1:0]),
      .rd_data (bk_rd_data)
   );

   dba_ram #(
      .WIDTH (dba_pkg::SPAN_W),
      .DEPTH (dba_pkg::OVERLAP_DEPTH)
   ) u_overlap_ram (
      .clock   (clock),
      .wr_en   (ov_wr_en),
      .wr_addr (ocnt_ff[dba_pkg::OIDX_W-1:0]),
      .wr_data (common),
      .rd_en   (ov_rd_en),
      .rd_addr (rd_ff[dba_pkg::OIDX_W-1:0]),
      .rd_data (ov_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rd_in         = rd_ff + dba_pkg::SCAN_W'(issue);
      pend_in       = issue;
      bcnt_in       = bcnt_ff;
      ocnt_in       = ocnt_ff;
      added_in      = added_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         dba_pkg::ST_IDLE: begin
            rd_in   = '0;
            pend_in = 1'b0;
            if (req_xfer) begin
               req_in.lo = req_start_time[dba_pkg::TIME_W-1:0];
               req_in.hi = req_end_time[dba_pkg::TIME_W-1:0];
               state_in  = dba_pkg::ST_SCAN_OVL;
            end
         end
         dba_pkg::ST_SCAN_OVL: begin
            if (pend_ff && hit) begin
               status_in = dba_pkg::STATUS_TRIPLE;
               state_in  = dba_pkg::ST_RESP;
            end else if (scan_done) begin
               rd_in    = '0;
               added_in = '0;
               state_in = dba_pkg::ST_COUNT;
            end
         end
         dba_pkg::ST_COUNT: begin
            if (pend_ff && hit) begin
               added_in = added_ff + dba_pkg::BCNT_W'(1);
            end
            if (scan_done) begin
               state_in = dba_pkg::ST_CHECK;
            end
         end
         dba_pkg::ST_CHECK: begin
            rd_in   = '0;
            pend_in = 1'b0;
            if ((bcnt_ff >= dba_pkg::BCNT_W'(dba_pkg::BOOKING_DEPTH)) ||
                (ovl_total > dba_pkg::SUM_W'(dba_pkg::OVERLAP_DEPTH))) begin
               status_in = dba_pkg::STATUS_FULL;
               state_in  = dba_pkg::ST_RESP;
            end else begin
               state_in = dba_pkg::ST_WRITE;
            end
         end
         dba_pkg::ST_WRITE: begin
            // Room was confirmed by the counting pass, so every hit is stored.
            if (ov_wr_en) begin
               ocnt_in = ocnt_ff + dba_pkg::OCNT_W'(1);
            end
            if (scan_done) begin
               state_in = dba_pkg::ST_STORE;
            end
         end
         dba_pkg::ST_STORE: begin
            bcnt_in   = bcnt_ff + dba_pkg::BCNT_W'(1);
            status_in = dba_pkg::STATUS_OK;
            state_in  = dba_pkg::ST_RESP;
         end
         dba_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               state_in      = dba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dba_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dba_pkg::ST_IDLE;
         rd_ff        <= '0;
         pend_ff      <= 1'b0;
         bcnt_ff      <= '0;
         ocnt_ff      <= '0;
         added_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ff        <= rd_in;
         pend_ff      <= pend_in;
         bcnt_ff      <= bcnt_in;
         ocnt_ff      <= ocnt_in;
         added_ff     <= added_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
   end

`ifndef SYNTHESIS
   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (bcnt_ff <= dba_pkg::BCNT_W'(dba_pkg::BOOKING_DEPTH)) &&
      (ocnt_ff <= dba_pkg::OCNT_W'(dba_pkg::OVERLAP_DEPTH)))
      else $error("table count exceeds its depth");

   a_booking_grows_on_store: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (bcnt_ff != $past(bcnt_ff)) |->
         $past(state_ff == dba_pkg::ST_STORE))
      else $error("booking count changed outside the store step");

   a_overlap_grows_on_write: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (ocnt_ff != $past(ocnt_ff)) |->
         $past(state_ff == dba_pkg::ST_WRITE))
      else $error("double region count changed outside the write pass");

   a_result_from_resp: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(rsp_valid_ff) |-> $past(state_ff == dba_pkg::ST_RESP))
      else $error("result raised outside the response step");
`endif

endmodule

// ----- bench/double_booking_admission_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double booking admission: result checker
// Keeps its own copy of the booking and double booked region tables, works out
// the status that each request transfer should earn, and compares it with
// every result transfer in order.
// ----------------------------------------------------------------------------
module double_booking_admission_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [dba_pkg::FIELD_BITS-1:0] req_start_time,
   input  logic [dba_pkg::FIELD_BITS-1:0] req_end_time,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [1:0]                     rsp_status,
   output int                             mismatch_count,
   output int                             outstanding_count
);

   dba_pkg::time_type   booked_lo [dba_pkg::BOOKING_DEPTH];
   dba_pkg::time_type   booked_hi [dba_pkg::BOOKING_DEPTH];
   int                  booked_total;
   dba_pkg::time_type   double_lo [dba_pkg::OVERLAP_DEPTH];
   dba_pkg::time_type   double_hi [dba_pkg::OVERLAP_DEPTH];
   int                  double_total;
   dba_pkg::status_type status_due_q [$];
   int                  fail_total;

   // Half-open spans meet when the larger start lies below the smaller end.
   function automatic bit spans_meet(dba_pkg::time_type a_lo, dba_pkg::time_type a_hi,
                                     dba_pkg::time_type b_lo, dba_pkg::time_type b_hi);
      dba_pkg::time_type lo;
      dba_pkg::time_type hi;
      lo = (a_lo > b_lo) ? a_lo : b_lo;
      hi = (a_hi < b_hi) ? a_hi : b_hi;
      return lo < hi;
   endfunction

   function automatic dba_pkg::status_type admit_interval(dba_pkg::time_type lo,
                                                          dba_pkg::time_type hi);
      int hits;
      hits = 0;
      for (int i = 0; i < double_total; i++) begin
         if (spans_meet(double_lo[i], double_hi[i], lo, hi)) return dba_pkg::STATUS_TRIPLE;
      end
      for (int i = 0; i < booked_total; i++) begin
         if (spans_meet(booked_lo[i], booked_hi[i], lo, hi)) hits++;
      end
      // Nothing is written unless both tables have room for the whole request.
      if (booked_total >= dba_pkg::BOOKING_DEPTH ||
          double_total + hits > dba_pkg::OVERLAP_DEPTH)
         return dba_pkg::STATUS_FULL;
      for (int i = 0; i < booked_total; i++) begin
         if (spans_meet(booked_lo[i], booked_hi[i], lo, hi) &&
             double_total < dba_pkg::OVERLAP_DEPTH) begin
            double_lo[double_total] = (booked_lo[i] > lo) ? booked_lo[i] : lo;
            double_hi[double_total] = (booked_hi[i] < hi) ? booked_hi[i] : hi;
            double_total++;
         end
      end
      booked_lo[booked_total] = lo;
      booked_hi[booked_total] = hi;
      booked_total++;
      return dba_pkg::STATUS_OK;
   endfunction

   always @(posedge clock) begin
      dba_pkg::status_type wanted;
      if (reset) begin
         booked_total = 0;
         double_total = 0;
         fail_total   = 0;
         status_due_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (status_due_q.size() == 0) begin
               $display("%0t: result with nothing pending, expected none, actual status %0d",
                        $time, rsp_status);
               fail_total++;
            end else begin
               wanted = status_due_q.pop_front();
               if (rsp_status !== wanted) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, wanted, rsp_status);
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            wanted = admit_interval(req_start_time[dba_pkg::TIME_W-1:0],
                                    req_end_time[dba_pkg::TIME_W-1:0]);
            status_due_q = {status_due_q, wanted};
         end
      end
      mismatch_count    <= fail_total;
      outstanding_count <= status_due_q.size();
   end

endmodule

// ----- bench/double_booking_admission_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double booking admission: testbench top
// Sends a directed set of intervals covering touching, empty, reversed and
// extreme spans, then random traffic built mostly from clusters of disjoint
// bookings crossed by one spanning interval, under three idling patterns.
// ----------------------------------------------------------------------------
module double_booking_admission_tb;

   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int PHASE_ITEMS  = 375;
   localparam int TAIL_CYCLES  = 300;

   logic                           clock          = 1'b0;
   logic                           reset          = 1'b1;
   logic                           req_valid      = 1'b0;
   logic                           req_stall;
   logic [dba_pkg::FIELD_BITS-1:0] req_start_time = '0;
   logic [dba_pkg::FIELD_BITS-1:0] req_end_time   = '0;
   logic                           rsp_valid;
   logic                           rsp_stall      = 1'b0;
   logic [1:0]                     rsp_status;

   int mismatch_count;
   int outstanding_count;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int requests_sent  = 0;
   int cycle_count    = 0;

   logic [dba_pkg::FIELD_BITS-1:0] used_times [$];

   double_booking_admission i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_start_time (req_start_time),
      .req_end_time   (req_end_time),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status)
   );

   double_booking_admission_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_start_time    (req_start_time),
      .req_end_time      (req_end_time),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .mismatch_count    (mismatch_count),
      .outstanding_count (outstanding_count)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [dba_pkg::FIELD_BITS-1:0] corner_time();
      case ($urandom_range(5))
         0: return 32'h0000_0000;
         1: return 32'h0000_0001;
         2: return 32'hFFFF_FFFE;
         3: return 32'hFFFF_FFFF;
         4: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Returns right after the edge at which the request transfer happened.
   task automatic send_interval(input logic [dba_pkg::FIELD_BITS-1:0] lo,
                                input logic [dba_pkg::FIELD_BITS-1:0] hi);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_start_time <= lo;
      req_end_time   <= hi;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      used_times = {used_times, lo, hi};
      requests_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding_count != 0) @(posedge clock);
   endtask

   task automatic send_random_item();
      logic [dba_pkg::FIELD_BITS-1:0] base;
      logic [dba_pkg::FIELD_BITS-1:0] lo;
      logic [dba_pkg::FIELD_BITS-1:0] hi;
      int                             parts;
      int                             pitch;
      int                             kind;
      kind = $urandom_range(99);
      if (kind < 35) begin
         // Disjoint bookings in a fresh region, then one interval across all
         // of them, then probes on and beside the new double regions.
         parts = ($urandom_range(7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
         pitch = $urandom_range(4, 64);
         base  = $urandom & 32'hFFF0_0000;
         for (int i = 0; i < parts; i++) begin
            lo = base + i * pitch;
            send_interval(lo, lo + $urandom_range(1, pitch - 1));
         end
         lo = base + $urandom_range(0, pitch / 2);
         hi = base + (parts - 1) * pitch + $urandom_range(1, pitch);
         send_interval(lo, hi);
         repeat ($urandom_range(1, 3)) begin
            lo = base + $urandom_range(0, parts * pitch);
            send_interval(lo, lo + $urandom_range(0, pitch));
         end
      end else if (kind < 55) begin
         // Edges of earlier requests, nudged by one either way.
         lo = used_times[$urandom_range(used_times.size() - 1)] + $urandom_range(2) - 1;
         case ($urandom_range(2))
            0: hi = used_times[$urandom_range(used_times.size() - 1)];
            1: hi = corner_time();
            default: hi = lo + $urandom_range(1, 40);
         endcase
         send_interval(lo, hi);
      end else if (kind < 70) begin
         lo = $urandom;
         send_interval(lo, $urandom_range(lo, 0));
      end else if (kind < 80) begin
         send_interval(corner_time(), corner_time());
      end else begin
         send_interval($urandom, $urandom);
      end
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct, input int items);
      int goal;
      // The sender holds off here until every pending result has come back.
      wait_for_results();
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
      goal = requests_sent + items;
      while (requests_sent < goal) send_random_item();
   endtask

   initial begin
      send_idle_pct  = 32;
      recv_stall_pct = 81;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_interval(32'd10, 32'd20);
      send_interval(32'd20, 32'd30);
      send_interval(32'd15, 32'd25);
      send_interval(32'd18, 32'd19);
      send_interval(32'd19, 32'd21);
      send_interval(32'd25, 32'd26);
      send_interval(32'd20, 32'd20);
      send_interval(32'd30, 32'd10);
      send_interval(32'h0000_0000, 32'hFFFF_FFFF);
      send_interval(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_interval(32'hFFFF_FFFF, 32'h0000_0000);
      send_interval(32'd0, 32'd1);
      send_interval(32'd0, 32'd10);
      send_interval(32'd0, 32'd0);
      send_interval(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_interval(32'h8000_0000, 32'hFFFF_FFFF);
      send_interval(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      send_interval(32'h7FFF_FFFF, 32'h8000_0001);
      send_interval(32'h5555_5555, 32'hAAAA_AAAA);
      send_interval(32'hAAAA_AAAA, 32'h5555_5555);

      run_phase(32, 81, PHASE_ITEMS);
      run_phase(81, 32, PHASE_ITEMS);
      run_phase(0, 0, PHASE_ITEMS);

      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/dba_pkg.sv
rtl/dba_ram.sv
rtl/dba_ovl.sv
rtl/double_booking_admission.sv
bench/double_booking_admission_checker.sv
bench/double_booking_admission_tb.sv
